// File: design/lfrmc_pkg.sv
// ---------------------------------------------------------------------------
// lfrmc_pkg
// Shared types, constants and the route table of the line follow controller.
// ---------------------------------------------------------------------------
`default_nettype none

package lfrmc_pkg;

   localparam int PWM_PERIOD  = 100;
   localparam int SAMPLE_BITS = 12;
   localparam int ROUTE_STEPS = 8;
   localparam int ROUTE_COUNT = 3;

   localparam int PHASE_W  = 7;
   localparam int DUTY_W   = 7;
   localparam int HOLD_W   = 16;
   localparam int COUNT_W  = 8;
   localparam int ROUTE_W  = 2;
   localparam int ADDR_W   = 5;
   localparam int DATA_W   = 32;

   typedef enum logic [1:0] {
      ACT_FWD   = 2'd0,
      ACT_LEFT  = 2'd1,
      ACT_RIGHT = 2'd2,
      ACT_STOP  = 2'd3
   } act_type;

   localparam logic [1:0] BR_OFF = 2'd0;
   localparam logic [1:0] BR_REV = 2'd1;
   localparam logic [1:0] BR_FWD = 2'd2;

   typedef enum logic [2:0] {
      REG_ROUTE_SELECT    = 3'd0,
      REG_CROSS_THRESHOLD = 3'd1,
      REG_DEAD_BAND       = 3'd2,
      REG_CRUISE_DUTY     = 3'd3,
      REG_CORRECTION_DUTY = 3'd4,
      REG_TURN_HOLD_TICKS = 3'd5
   } reg_idx_type;

   typedef struct packed {
      logic [ROUTE_W-1:0]     route_select;
      logic [SAMPLE_BITS-1:0] crossing_threshold;
      logic [SAMPLE_BITS-1:0] dead_band;
      logic [DUTY_W-1:0]      cruise_duty;
      logic [DUTY_W-1:0]      correction_duty;
      logic [HOLD_W-1:0]      turn_hold_ticks;
   } cfg_type;

   typedef struct packed {
      logic               left_pwm_out;
      logic               right_pwm_out;
      logic [1:0]         left_bridge;
      logic [1:0]         right_bridge;
      logic [COUNT_W-1:0] crossings_seen;
      act_type            last_action;
      logic               holding;
   } rsp_type;

   // columns past the route length hold stop
   localparam logic [1:0] ROUTE_TABLE [3][16] = '{
      '{2'd0, 2'd1, 2'd1, 2'd0, 2'd2, 2'd1, 2'd2, 2'd3,
        2'd3, 2'd3, 2'd3, 2'd3, 2'd3, 2'd3, 2'd3, 2'd3},
      '{2'd1, 2'd2, 2'd1, 2'd2, 2'd0, 2'd0, 2'd3, 2'd3,
        2'd3, 2'd3, 2'd3, 2'd3, 2'd3, 2'd3, 2'd3, 2'd3},
      '{2'd2, 2'd0, 2'd2, 2'd1, 2'd2, 2'd1, 2'd0, 2'd3,
        2'd3, 2'd3, 2'd3, 2'd3, 2'd3, 2'd3, 2'd3, 2'd3}
   };

   function automatic act_type route_lookup(input logic [ROUTE_W-1:0] route,
                                            input logic [COUNT_W-1:0] count);
      logic [1:0] row;
      logic [3:0] col;
      act_type    act;
      row = route - 2'd1;
      col = 4'(count - 8'd1);
      act = ACT_STOP;
      if (route != '0 && int'(route) <= ROUTE_COUNT &&
          count != '0 && int'(count) <= ROUTE_STEPS && int'(count) <= 16) begin
         act = act_type'(ROUTE_TABLE[row][col]);
      end
      return act;
   endfunction

endpackage

`default_nettype wire

// File: design/lfrmc_csr.sv
// ---------------------------------------------------------------------------
// lfrmc_csr
// Configuration registers behind a simple APB-style slave port.
// ---------------------------------------------------------------------------
`default_nettype none

module lfrmc_csr (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         csr_psel,
   input  wire logic                         csr_penable,
   input  wire logic                         csr_pwrite,
   input  wire logic [lfrmc_pkg::ADDR_W-1:0] csr_paddr,
   input  wire logic [lfrmc_pkg::DATA_W-1:0] csr_pwdata,
   output logic      [lfrmc_pkg::DATA_W-1:0] csr_prdata,
   output logic                              csr_pready,
   output lfrmc_pkg::cfg_type                cfg
);
   import lfrmc_pkg::*;

   cfg_type     cfg_ff, cfg_in;
   reg_idx_type idx;
   logic        wr_en;

   assign idx        = reg_idx_type'(csr_paddr[ADDR_W-1:2]);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (idx)
            REG_ROUTE_SELECT:    cfg_in.route_select       = csr_pwdata[ROUTE_W-1:0];
            REG_CROSS_THRESHOLD: cfg_in.crossing_threshold = csr_pwdata[SAMPLE_BITS-1:0];
            REG_DEAD_BAND:       cfg_in.dead_band          = csr_pwdata[SAMPLE_BITS-1:0];
            REG_CRUISE_DUTY:     cfg_in.cruise_duty        = csr_pwdata[DUTY_W-1:0];
            REG_CORRECTION_DUTY: cfg_in.correction_duty    = csr_pwdata[DUTY_W-1:0];
            REG_TURN_HOLD_TICKS: cfg_in.turn_hold_ticks    = csr_pwdata[HOLD_W-1:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      csr_prdata = '0;
      unique case (idx)
         REG_ROUTE_SELECT:    csr_prdata = DATA_W'(cfg_ff.route_select);
         REG_CROSS_THRESHOLD: csr_prdata = DATA_W'(cfg_ff.crossing_threshold);
         REG_DEAD_BAND:       csr_prdata = DATA_W'(cfg_ff.dead_band);
         REG_CRUISE_DUTY:     csr_prdata = DATA_W'(cfg_ff.cruise_duty);
         REG_CORRECTION_DUTY: csr_prdata = DATA_W'(cfg_ff.correction_duty);
         REG_TURN_HOLD_TICKS: csr_prdata = DATA_W'(cfg_ff.turn_hold_ticks);
         default:             csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.route_select       <= ROUTE_W'(1);
         cfg_ff.crossing_threshold <= SAMPLE_BITS'(2000);
         cfg_ff.dead_band          <= SAMPLE_BITS'(2);
         cfg_ff.cruise_duty        <= DUTY_W'(10);
         cfg_ff.correction_duty    <= DUTY_W'(20);
         cfg_ff.turn_hold_ticks    <= HOLD_W'(300 * 100);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

// File: design/lfrmc_step.sv
// ---------------------------------------------------------------------------
// lfrmc_step
// Controller state and the per-tick decision: hold, crossing or steering.
// ---------------------------------------------------------------------------
`default_nettype none

module lfrmc_step (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              tick,
   input  wire logic [lfrmc_pkg::SAMPLE_BITS-1:0] left_sample,
   input  wire logic [lfrmc_pkg::SAMPLE_BITS-1:0] right_sample,
   input  wire logic [lfrmc_pkg::SAMPLE_BITS-1:0] crossing_sample,
   input  wire lfrmc_pkg::cfg_type                cfg,
   output lfrmc_pkg::rsp_type                     rsp
);
   import lfrmc_pkg::*;

   logic [PHASE_W-1:0] phase_ff, phase_in, phase_inc;
   logic [DUTY_W-1:0]  left_duty_ff, left_duty_in;
   logic [DUTY_W-1:0]  right_duty_ff, right_duty_in;
   logic [1:0]         left_br_ff, left_br_in;
   logic [1:0]         right_br_ff, right_br_in;
   logic               on_cross_ff, on_cross_in;
   logic [COUNT_W-1:0] count_ff, count_in, count_inc;
   logic [HOLD_W-1:0]  hold_ff, hold_in;
   act_type            action_ff, action_in, lookup_act;

   logic                   left_ge;
   logic [SAMPLE_BITS-1:0] diff;
   logic                   out_of_band;

   assign count_inc  = count_ff + 8'd1;
   assign lookup_act = route_lookup(cfg.route_select, count_inc);

   // magnitude of left - right, and which side leads
   assign left_ge     = left_sample >= right_sample;
   assign diff        = left_ge ? left_sample - right_sample : right_sample - left_sample;
   assign out_of_band = diff > cfg.dead_band;

   assign phase_inc = phase_ff + 7'd1;
   assign phase_in  = (int'(phase_inc) >= PWM_PERIOD) ? '0 : phase_inc;

   always_comb begin
      left_duty_in  = left_duty_ff;
      right_duty_in = right_duty_ff;
      left_br_in    = left_br_ff;
      right_br_in   = right_br_ff;
      on_cross_in   = on_cross_ff;
      count_in      = count_ff;
      hold_in       = hold_ff;
      action_in     = action_ff;
      if (hold_ff != '0) begin
         hold_in = hold_ff - 16'd1;
      end else if (crossing_sample > cfg.crossing_threshold) begin
         if (!on_cross_ff) begin
            on_cross_in = 1'b1;
            count_in    = count_inc;
            action_in   = lookup_act;
            unique case (lookup_act)
               ACT_FWD: begin
                  left_br_in  = BR_FWD;
                  right_br_in = BR_FWD;
               end
               ACT_LEFT: begin
                  left_br_in  = BR_REV;
                  right_br_in = BR_FWD;
               end
               ACT_RIGHT: begin
                  left_br_in  = BR_FWD;
                  right_br_in = BR_REV;
               end
               default: begin
                  left_br_in  = BR_OFF;
                  right_br_in = BR_OFF;
               end
            endcase
            if (lookup_act == ACT_STOP) begin
               left_duty_in  = '0;
               right_duty_in = '0;
            end else begin
               left_duty_in  = cfg.cruise_duty;
               right_duty_in = cfg.cruise_duty;
               hold_in       = cfg.turn_hold_ticks;
            end
         end
      end else begin
         on_cross_in   = 1'b0;
         left_br_in    = BR_FWD;
         right_br_in   = BR_FWD;
         left_duty_in  = cfg.cruise_duty;
         right_duty_in = cfg.cruise_duty;
         // the lagging side gets the correction duty
         if (out_of_band && left_ge) begin
            right_duty_in = cfg.correction_duty;
         end else if (out_of_band) begin
            left_duty_in = cfg.correction_duty;
         end
      end
   end

   always_comb begin
      rsp.left_pwm_out   = phase_in < left_duty_in;
      rsp.right_pwm_out  = phase_in < right_duty_in;
      rsp.left_bridge    = left_br_in;
      rsp.right_bridge   = right_br_in;
      rsp.crossings_seen = count_in;
      rsp.last_action    = action_in;
      rsp.holding        = hold_in != '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= '0;
         left_duty_ff  <= '0;
         right_duty_ff <= '0;
         left_br_ff    <= BR_OFF;
         right_br_ff   <= BR_OFF;
         on_cross_ff   <= 1'b0;
         count_ff      <= '0;
         hold_ff       <= '0;
         action_ff     <= ACT_STOP;
      end else if (tick) begin
         phase_ff      <= phase_in;
         left_duty_ff  <= left_duty_in;
         right_duty_ff <= right_duty_in;
         left_br_ff    <= left_br_in;
         right_br_ff   <= right_br_in;
         on_cross_ff   <= on_cross_in;
         count_ff      <= count_in;
         hold_ff       <= hold_in;
         action_ff     <= action_in;
      end
   end

endmodule

`default_nettype wire

// File: design/line_follow_route_motor_controller.sv
// ---------------------------------------------------------------------------
// line_follow_route_motor_controller
// Line follower with route table: sensor samples in, PWM and bridge drive out.
//
//   channel   ports          direction   handshake
//   ------------------------------------------------------------
//   samples   req_*          in          req_valid / req_stall
//   drive     rsp_*          out         rsp_valid / rsp_stall
//   config    csr_*          in/out      apb-style, pready tied high
//
// One item per cycle sustained while rsp_stall is low; an item is held in the input
// register and then loaded into the result register, from which its result
// can be taken.
// Synchronous reset clears the controller state and loads register defaults.
// A stalled result holds while the input register keeps one more item;
// req_stall rises only when both are full and rsp_stall is high.
// ---------------------------------------------------------------------------
`default_nettype none

module line_follow_route_motor_controller (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic [lfrmc_pkg::SAMPLE_BITS-1:0] req_left_sample,
   input  wire logic [lfrmc_pkg::SAMPLE_BITS-1:0] req_right_sample,
   input  wire logic [lfrmc_pkg::SAMPLE_BITS-1:0] req_crossing_sample,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic                                   rsp_left_pwm_out,
   output logic                                   rsp_right_pwm_out,
   output logic      [1:0]                        rsp_left_bridge,
   output logic      [1:0]                        rsp_right_bridge,
   output logic      [lfrmc_pkg::COUNT_W-1:0]     rsp_crossings_seen,
   output logic      [1:0]                        rsp_last_action,
   output logic                                   rsp_holding,
   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [lfrmc_pkg::ADDR_W-1:0]      csr_paddr,
   input  wire logic [lfrmc_pkg::DATA_W-1:0]      csr_pwdata,
   output logic      [lfrmc_pkg::DATA_W-1:0]      csr_prdata,
   output logic                                   csr_pready
);
   import lfrmc_pkg::*;

   cfg_type cfg;
   rsp_type step_rsp;
   rsp_type rsp_ff;

   logic                   in_valid_ff, in_valid_in;
   logic [SAMPLE_BITS-1:0] left_ff, right_ff, cross_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   out_load, in_load;

   assign out_load    = !rsp_valid_ff || !rsp_stall;
   assign in_load     = !in_valid_ff || out_load;
   assign req_stall   = !in_load;
   assign in_valid_in = in_load ? req_valid : in_valid_ff;
   assign rsp_valid_in = out_load ? in_valid_ff : rsp_valid_ff;

   lfrmc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   lfrmc_step u_step (
      .clock           (clock),
      .reset           (reset),
      .tick            (in_valid_ff && out_load),
      .left_sample     (left_ff),
      .right_sample    (right_ff),
      .crossing_sample (cross_ff),
      .cfg             (cfg),
      .rsp             (step_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_load && req_valid) begin
         left_ff  <= req_left_sample;
         right_ff <= req_right_sample;
         cross_ff <= req_crossing_sample;
      end
      if (out_load && in_valid_ff) begin
         rsp_ff <= step_rsp;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_left_pwm_out   = rsp_ff.left_pwm_out;
   assign rsp_right_pwm_out  = rsp_ff.right_pwm_out;
   assign rsp_left_bridge    = rsp_ff.left_bridge;
   assign rsp_right_bridge   = rsp_ff.right_bridge;
   assign rsp_crossings_seen = rsp_ff.crossings_seen;
   assign rsp_last_action    = rsp_ff.last_action;
   assign rsp_holding        = rsp_ff.holding;

endmodule

`default_nettype wire

// File: design/lfrmc_checker.sv
// ---------------------------------------------------------------------------
// lfrmc_checker
// Port-level checks of the line follow controller, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

module lfrmc_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_stall,
   input wire logic       rsp_left_pwm_out,
   input wire logic       rsp_right_pwm_out,
   input wire logic [1:0] rsp_left_bridge,
   input wire logic [1:0] rsp_right_bridge,
   input wire logic [7:0] rsp_crossings_seen,
   input wire logic [1:0] rsp_last_action,
   input wire logic       rsp_holding
);
   import lfrmc_pkg::*;

   // a stalled item keeps its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_left_pwm_out) &&
         $stable(rsp_right_pwm_out) && $stable(rsp_left_bridge) &&
         $stable(rsp_right_bridge) && $stable(rsp_crossings_seen) &&
         $stable(rsp_last_action) && $stable(rsp_holding))
      else $error("stalled item changed");

   // nothing comes out right after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("item after reset");

   // a hold only runs behind a driving route action
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_holding |-> rsp_last_action != ACT_STOP &&
         rsp_left_bridge != BR_OFF && rsp_right_bridge != BR_OFF)
      else $error("hold without a driving action");

   // a reversed bridge only follows the matching turn
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_left_bridge == BR_REV || rsp_right_bridge == BR_REV) |->
         (rsp_left_bridge == BR_REV && rsp_last_action == ACT_LEFT) ||
         (rsp_right_bridge == BR_REV && rsp_last_action == ACT_RIGHT))
      else $error("reverse drive without a turn");

endmodule

bind line_follow_route_motor_controller lfrmc_checker u_lfrmc_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_left_pwm_out   (rsp_left_pwm_out),
   .rsp_right_pwm_out  (rsp_right_pwm_out),
   .rsp_left_bridge    (rsp_left_bridge),
   .rsp_right_bridge   (rsp_right_bridge),
   .rsp_crossings_seen (rsp_crossings_seen),
   .rsp_last_action    (rsp_last_action),
   .rsp_holding        (rsp_holding)
);

`default_nettype wire

// File: tb/tb.sv
// ---------------------------------------------------------------------------
// tb
// Line follow route motor controller: sensor items in, drive items out.
//
// Each accepted sensor item is run through a cycle model of the controller,
// covering the turn hold, crossing edge detection with route lookup, and
// steering and pwm phase. That gives the drive item that must come back.
// Results are compared field by field in order. Register settings change
// between traffic phases while the block is idle. Both channels idle at
// random in three different mixes.
// ---------------------------------------------------------------------------
`default_nettype none

module tb;
   import lfrmc_pkg::*;

   localparam int CLK_HALF      = 10;
   localparam int RESET_CYCLES  = 8;
   localparam int SETTLE_CYCLES = 6;
   localparam int LIMIT_TIME    = 20_000_000;
   localparam int LEVEL_MAX     = (1 << SAMPLE_BITS) - 1;

   // action per route row and crossing number 1..8
   localparam act_type ROUTE_PLAN [3][8] = '{
      '{ACT_FWD, ACT_LEFT, ACT_LEFT, ACT_FWD, ACT_RIGHT, ACT_LEFT, ACT_RIGHT, ACT_STOP},
      '{ACT_LEFT, ACT_RIGHT, ACT_LEFT, ACT_RIGHT, ACT_FWD, ACT_FWD, ACT_STOP, ACT_STOP},
      '{ACT_RIGHT, ACT_FWD, ACT_RIGHT, ACT_LEFT, ACT_RIGHT, ACT_LEFT, ACT_FWD, ACT_STOP}
   };

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [SAMPLE_BITS-1:0] req_left_sample = '0;
   logic [SAMPLE_BITS-1:0] req_right_sample = '0;
   logic [SAMPLE_BITS-1:0] req_crossing_sample = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic                   rsp_left_pwm_out;
   logic                   rsp_right_pwm_out;
   logic [1:0]             rsp_left_bridge;
   logic [1:0]             rsp_right_bridge;
   logic [COUNT_W-1:0]     rsp_crossings_seen;
   logic [1:0]             rsp_last_action;
   logic                   rsp_holding;
   logic                   csr_psel = 1'b0;
   logic                   csr_penable = 1'b0;
   logic                   csr_pwrite = 1'b0;
   logic [ADDR_W-1:0]      csr_paddr = '0;
   logic [DATA_W-1:0]      csr_pwdata = '0;
   logic [DATA_W-1:0]      csr_prdata;
   logic                   csr_pready;

   int send_idle_pct = 0;
   int rsp_idle_pct = 0;
   int settings_run = 0;

   class drive_scoreboard;
      logic [ROUTE_W-1:0]     route_sel;
      logic [SAMPLE_BITS-1:0] cross_level;
      logic [SAMPLE_BITS-1:0] band;
      logic [DUTY_W-1:0]      cruise;
      logic [DUTY_W-1:0]      correction;
      logic [HOLD_W-1:0]      hold_ticks;

      logic [PHASE_W-1:0]     phase;
      logic [DUTY_W-1:0]      left_duty;
      logic [DUTY_W-1:0]      right_duty;
      logic [1:0]             left_br;
      logic [1:0]             right_br;
      logic                   over_line;
      logic [COUNT_W-1:0]     count;
      logic [HOLD_W-1:0]      hold_left;
      act_type                action;

      rsp_type drive_q[$];
      int fails;
      int items;
      int crossings;
      int corrections;
      int held;
      int action_hits[4];

      function new();
         route_sel   = 2'd1;
         cross_level = 12'd2000;
         band        = 12'd2;
         cruise      = 7'd10;
         correction  = 7'd20;
         hold_ticks  = 16'd30000;
         phase       = '0;
         left_duty   = '0;
         right_duty  = '0;
         left_br     = BR_OFF;
         right_br    = BR_OFF;
         over_line   = 1'b0;
         count       = '0;
         hold_left   = '0;
         action      = ACT_STOP;
         fails       = 0;
         items       = 0;
         crossings   = 0;
         corrections = 0;
         held        = 0;
         foreach (action_hits[i]) action_hits[i] = 0;
      endfunction

      function void set_reg(reg_idx_type idx, logic [DATA_W-1:0] value);
         case (idx)
            REG_ROUTE_SELECT:    route_sel = value[ROUTE_W-1:0];
            REG_CROSS_THRESHOLD: cross_level = value[SAMPLE_BITS-1:0];
            REG_DEAD_BAND:       band = value[SAMPLE_BITS-1:0];
            REG_CRUISE_DUTY:     cruise = value[DUTY_W-1:0];
            REG_CORRECTION_DUTY: correction = value[DUTY_W-1:0];
            REG_TURN_HOLD_TICKS: hold_ticks = value[HOLD_W-1:0];
            default: ;
         endcase
      endfunction

      function void set_drive(logic [1:0] lb, logic [1:0] rb,
                              logic [DUTY_W-1:0] ld, logic [DUTY_W-1:0] rd);
         left_br    = lb;
         right_br   = rb;
         left_duty  = ld;
         right_duty = rd;
      endfunction

      // route 0 and crossing numbers past the plan (or 0 after wrap) mean stop
      function act_type plan_action();
         if (route_sel == '0 || int'(route_sel) > ROUTE_COUNT ||
             count == '0 || int'(count) > ROUTE_STEPS)
            return ACT_STOP;
         return ROUTE_PLAN[route_sel - 2'd1][3'(count - 8'd1)];
      endfunction

      function void note_sample(logic [SAMPLE_BITS-1:0] left_s,
                                logic [SAMPLE_BITS-1:0] right_s,
                                logic [SAMPLE_BITS-1:0] mark_s);
         int      err;
         int      tol;
         int      next_phase;
         rsp_type want;
         items++;
         if (hold_left != '0) begin
            // sensing is blocked, edge flag keeps its value
            hold_left--;
            held++;
         end else if (mark_s > cross_level) begin
            if (!over_line) begin
               over_line = 1'b1;
               count++;
               crossings++;
               action = plan_action();
               action_hits[action]++;
               case (action)
                  ACT_FWD:   set_drive(BR_FWD, BR_FWD, cruise, cruise);
                  ACT_LEFT:  set_drive(BR_REV, BR_FWD, cruise, cruise);
                  ACT_RIGHT: set_drive(BR_FWD, BR_REV, cruise, cruise);
                  default:   set_drive(BR_OFF, BR_OFF, '0, '0);
               endcase
               if (action != ACT_STOP) hold_left = hold_ticks;
            end
         end else begin
            over_line = 1'b0;
            err = int'(left_s) - int'(right_s);
            tol = int'(band);
            if (err > tol) begin
               set_drive(BR_FWD, BR_FWD, cruise, correction);
               corrections++;
            end else if (err < -tol) begin
               set_drive(BR_FWD, BR_FWD, correction, cruise);
               corrections++;
            end else begin
               set_drive(BR_FWD, BR_FWD, cruise, cruise);
            end
         end
         next_phase = int'(phase) + 1;
         if (next_phase >= PWM_PERIOD) next_phase = 0;
         phase = next_phase[PHASE_W-1:0];
         want.left_pwm_out   = phase < left_duty;
         want.right_pwm_out  = phase < right_duty;
         want.left_bridge    = left_br;
         want.right_bridge   = right_br;
         want.crossings_seen = count;
         want.last_action    = action;
         want.holding        = hold_left != '0;
         drive_q.push_back(want);
      endfunction

      function void compare_field(string name, int want, int seen);
         if (want != seen) begin
            fails++;
            $error("%s: expected %0d, got %0d", name, want, seen);
         end
      endfunction

      function void check_drive(rsp_type seen);
         rsp_type want;
         if (drive_q.size() == 0) begin
            fails++;
            $error("drive item with no prediction waiting");
            return;
         end
         want = drive_q.pop_front();
         compare_field("left_pwm_out", want.left_pwm_out, seen.left_pwm_out);
         compare_field("right_pwm_out", want.right_pwm_out, seen.right_pwm_out);
         compare_field("left_bridge", want.left_bridge, seen.left_bridge);
         compare_field("right_bridge", want.right_bridge, seen.right_bridge);
         compare_field("crossings_seen", want.crossings_seen, seen.crossings_seen);
         compare_field("last_action", want.last_action, seen.last_action);
         compare_field("holding", want.holding, seen.holding);
      endfunction

      function int pending();
         return drive_q.size();
      endfunction
   endclass

   drive_scoreboard sb;

   line_follow_route_motor_controller dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_left_sample     (req_left_sample),
      .req_right_sample    (req_right_sample),
      .req_crossing_sample (req_crossing_sample),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_left_pwm_out    (rsp_left_pwm_out),
      .rsp_right_pwm_out   (rsp_right_pwm_out),
      .rsp_left_bridge     (rsp_left_bridge),
      .rsp_right_bridge    (rsp_right_bridge),
      .rsp_crossings_seen  (rsp_crossings_seen),
      .rsp_last_action     (rsp_last_action),
      .rsp_holding         (rsp_holding),
      .csr_psel            (csr_psel),
      .csr_penable         (csr_penable),
      .csr_pwrite          (csr_pwrite),
      .csr_paddr           (csr_paddr),
      .csr_pwdata          (csr_pwdata),
      .csr_prdata          (csr_prdata),
      .csr_pready          (csr_pready)
   );

   always begin
      #CLK_HALF clock = 1'b1;
      #CLK_HALF clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_stall <= !reset && ($urandom_range(0, 99) < rsp_idle_pct);
   end

   // values read here are the ones present at the edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall)
            sb.note_sample(req_left_sample, req_right_sample, req_crossing_sample);
         if (rsp_valid && !rsp_stall)
            sb.check_drive(rsp_type'({rsp_left_pwm_out, rsp_right_pwm_out,
                                      rsp_left_bridge, rsp_right_bridge,
                                      rsp_crossings_seen, rsp_last_action,
                                      rsp_holding}));
      end
   end

   function automatic logic [SAMPLE_BITS-1:0] any_level();
      return SAMPLE_BITS'($urandom_range(0, LEVEL_MAX));
   endfunction

   function automatic logic [SAMPLE_BITS-1:0] below_mark();
      return SAMPLE_BITS'($urandom_range(0, int'(sb.cross_level)));
   endfunction

   function automatic logic [SAMPLE_BITS-1:0] above_mark();
      if (int'(sb.cross_level) == LEVEL_MAX) return any_level();
      return SAMPLE_BITS'($urandom_range(int'(sb.cross_level) + 1, LEVEL_MAX));
   endfunction

   // right reading placed inside or just past the dead band, or at a random level
   function automatic logic [SAMPLE_BITS-1:0] partner_level(logic [SAMPLE_BITS-1:0] left_s);
      int tol;
      int diff;
      int level;
      tol = int'(sb.band);
      case ($urandom_range(0, 3))
         0:       diff = int'($urandom_range(0, 2 * tol)) - tol;
         1:       diff = tol + 1;
         2:       diff = -(tol + 1);
         default: return any_level();
      endcase
      level = int'(left_s) - diff;
      if (level < 0) level = 0;
      if (level > LEVEL_MAX) level = LEVEL_MAX;
      return SAMPLE_BITS'(level);
   endfunction

   task automatic push_sample(input logic [SAMPLE_BITS-1:0] left_s,
                              input logic [SAMPLE_BITS-1:0] right_s,
                              input logic [SAMPLE_BITS-1:0] mark_s);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid           <= 1'b1;
      req_left_sample     <= left_s;
      req_right_sample    <= right_s;
      req_crossing_sample <= mark_s;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic wait_for_drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // psel stays up across a burst of writes, dropped by apply_setting
   task automatic csr_write(input reg_idx_type idx, input logic [DATA_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= ADDR_W'(4 * int'(idx));
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      sb.set_reg(idx, value);
   endtask

   task automatic apply_setting(input int route, input int level, input int tol,
                                input int cruise_d, input int corr_d, input int hold_t);
      csr_write(REG_ROUTE_SELECT, DATA_W'(route));
      csr_write(REG_CROSS_THRESHOLD, DATA_W'(level));
      csr_write(REG_DEAD_BAND, DATA_W'(tol));
      csr_write(REG_CRUISE_DUTY, DATA_W'(cruise_d));
      csr_write(REG_CORRECTION_DUTY, DATA_W'(corr_d));
      csr_write(REG_TURN_HOLD_TICKS, DATA_W'(hold_t));
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      settings_run++;
   endtask

   // mostly line runs followed by a crossing pulse, some pure noise
   task automatic run_traffic(input int n_items);
      int                     sent;
      int                     steps;
      logic [SAMPLE_BITS-1:0] left_s;
      sent = 0;
      while (sent < n_items) begin
         if ($urandom_range(0, 99) < 15) begin
            push_sample(any_level(), any_level(), any_level());
            sent++;
         end else begin
            steps = $urandom_range(1, 3);
            repeat (steps) begin
               left_s = any_level();
               push_sample(left_s, partner_level(left_s), below_mark());
               sent++;
            end
            steps = $urandom_range(1, 2);
            repeat (steps) begin
               push_sample(any_level(), any_level(), above_mark());
               sent++;
            end
         end
      end
   endtask

   initial begin
      #LIMIT_TIME;
      $display("Verification failed");
      $finish;
   end

   initial begin
      sb = new();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // register defaults: steering only, crossing reading right at threshold
      push_sample(12'd4095, 12'd0, 12'd0);
      push_sample(12'd0, 12'd4095, 12'd2000);
      wait_for_drain();

      apply_setting(1, 2000, 2, 10, 20, 2);
      push_sample(12'd0, 12'd0, 12'd0);
      push_sample(12'd2002, 12'd2000, 12'd0);      // error right at the band
      push_sample(12'd1997, 12'd2000, 12'd0);      // left lags
      push_sample(12'd2003, 12'd2000, 12'd0);      // right lags
      push_sample(12'd4095, 12'd4095, 12'd2001);   // first crossing, forward
      push_sample(12'd0, 12'd4095, 12'd4095);      // held
      push_sample(12'd4095, 12'd0, 12'd0);         // held, sensing ignored
      push_sample(12'd0, 12'd0, 12'd4095);         // still on the same crossing
      push_sample(12'd0, 12'd0, 12'd0);
      push_sample(12'd0, 12'd0, 12'd4095);         // second crossing, left turn
      push_sample(12'd0, 12'd0, 12'd0);
      push_sample(12'd0, 12'd0, 12'd0);
      push_sample(12'd0, 12'd0, 12'd0);
      push_sample(12'd0, 12'd0, 12'd4095);         // third crossing
      push_sample(12'd5, 12'd5, 12'd0);
      push_sample(12'd5, 12'd5, 12'd0);
      push_sample(12'd4095, 12'd4095, 12'd4095);
      push_sample(12'd2730, 12'd1365, 12'd1365);
      wait_for_drain();

      for (int p = 0; p < 8; p++) begin
         case (p)
            0: apply_setting(1, 2000, 2, 10, 20, 0);
            1: apply_setting(2, 0, 4095, 100, 0, 1);
            2: apply_setting(3, 4095, 0, 0, 100, 0);
            3: apply_setting(0, 1000, 100, 55, 77, 3);
            7: apply_setting(2, 2500, 50, 30, 90, 65535);
            default: apply_setting($urandom_range(0, 3), $urandom_range(0, LEVEL_MAX),
                                   $urandom_range(0, 300), $urandom_range(0, 100),
                                   $urandom_range(0, 100), $urandom_range(0, 3));
         endcase
         if (p < 3) begin
            send_idle_pct = 13;
            rsp_idle_pct  = 83;
         end else if (p < 5) begin
            send_idle_pct = 83;
            rsp_idle_pct  = 13;
         end else begin
            send_idle_pct = 0;
            rsp_idle_pct  = 0;
         end
         run_traffic(p == 7 ? 60 : 270);
         wait_for_drain();
      end

      $display("run covered %0d sensor items under %0d register settings, %0d crossings",
               sb.items, settings_run, sb.crossings);
      $display("actions fwd/left/right/stop %0d/%0d/%0d/%0d, %0d corrections, %0d held ticks",
               sb.action_hits[0], sb.action_hits[1], sb.action_hits[2],
               sb.action_hits[3], sb.corrections, sb.held);
      if (sb.fails == 0 && sb.pending() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

`default_nettype wire

// File: files.f
design/lfrmc_pkg.sv
design/lfrmc_csr.sv
design/lfrmc_step.sv
design/line_follow_route_motor_controller.sv
design/lfrmc_checker.sv
tb/tb.sv
